@@ hdl/sas_pkg.sv @@
// Shared types and constants for the sparse adjacency store.
package sas_pkg;

    localparam int IDX_W   = 6;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int DEG_W   = 11;
    localparam int RES_CAP = 64;
    localparam int CNT_W   = $clog2(RES_CAP + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT, REQ_CONTAINS, REQ_READ_ROW, REQ_READ_COL,
        REQ_CLEAR_ROW, REQ_CLEAR_COL, REQ_CLEAR_ALL
    } t_req;

    typedef enum logic [STAT_W-1:0] {ST_OK, ST_RANGE, ST_FULL} t_status;

    typedef enum logic [1:0] {RET_INS, RET_CLR, RET_SWEEP} t_ret;

    typedef enum logic [4:0] {
        SM_IDLE, SM_DECODE, SM_EMIT,
        SM_INS_RDPOS, SM_INS_POS, SM_INS_SHCHK, SM_INS_SHWR,
        SM_ADJ_RD, SM_ADJ_WR,
        SM_SEG_A, SM_SEG_B, SM_SEG_C, SM_SEG_D,
        SM_DN_CHK, SM_DN_WR,
        SM_SW_SEG, SM_SW_RDHI, SM_SW_HI,
        SM_SC_CHK, SM_SC_CMP,
        SM_RD_CHK, SM_ST_RD, SM_ST_EM
    } t_state;

    typedef enum logic [2:0] {SR_NONE, SR_IDX, SR_IDX1, SR_SEG, SR_SEG1, SR_I} t_srd;
    typedef enum logic [1:0] {ER_NONE, ER_KM1, ER_K, ER_P} t_erd;
    typedef enum logic [1:0] {WR_NONE, WR_UP, WR_POS, WR_DN} t_ewr;
    typedef enum logic [2:0] {K_NONE, K_TOT, K_HI, K_INC, K_DEC, K_LO1} t_kop;
    typedef enum logic [1:0] {LO_NONE, LO_Q, LO_INC} t_loop;
    typedef enum logic [1:0] {D_NONE, D_SPAN, D_ONE} t_dop;
    typedef enum logic [1:0] {I_NONE, I_IDX1, I_SEG1, I_INC} t_iop;
    typedef enum logic [1:0] {S_NONE, S_ZERO, S_INC} t_sop;
    typedef enum logic [1:0] {C_NONE, C_CLR, C_INC} t_cop;

    typedef struct packed {
        logic    latch;
        t_srd    s_rd;
        logic    s_wr;
        t_erd    e_rd;
        t_ewr    e_wr;
        t_loop   lo_op;
        logic    hi_ld;
        t_kop    k_op;
        t_dop    d_op;
        t_iop    i_op;
        t_sop    s_op;
        t_cop    c_op;
        logic    sel_set;
        logic    sel_val;
        logic    sel_flip;
        logic    nodes_upd;
        logic    tot_upd;
        logic    adj_up;
        logic    st_set;
        t_status st_val;
        logic    found_set;
        logic    clr_all;
        logic    emit_single;
        logic    emit_stream;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic sel;
        logic ins_oor;
        logic full;
        logic row_oor;
        logic col_oor;
        logic k_gt_hi;
        logic k_lt_tot;
        logic i_le_max;
        logic s_lt_nodes;
        logic lo_lt_hi;
        logic match;
        logic d_zero;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hdl/sas_datapath.sv @@
// Datapath: offset and entry memories, pointers, counters and result register.
module sas_datapath import sas_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [IDX_W-1:0]   i_row_index,
    input  logic [IDX_W-1:0]   i_col_index,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic               o_found,
    output logic               o_neighbour_valid,
    output logic [IDX_W-1:0]   o_neighbour,
    output logic [DEG_W-1:0]   o_degree,
    output logic               o_last
);

    localparam int EW     = $clog2(MAX_EDGES + 1);
    localparam int AW     = $clog2(MAX_EDGES);
    localparam int SW     = $clog2(MAX_NODES + 1);
    localparam int SW1    = $clog2(MAX_NODES + 2);
    localparam int NDEPTH = MAX_NODES + 1;
    localparam int XW     = IDX_W + 1;
    localparam int LW     = (EW > CNT_W) ? EW : CNT_W;

    logic [EW-1:0]    rs_mem [NDEPTH];
    logic [EW-1:0]    cs_mem [NDEPTH];
    logic             r_rs_vld [NDEPTH];
    logic             r_cs_vld [NDEPTH];
    logic [IDX_W-1:0] re_mem [MAX_EDGES];
    logic [IDX_W-1:0] ce_mem [MAX_EDGES];

    logic [REQ_W-1:0] r_req;
    logic [IDX_W-1:0] r_row, r_col;
    logic             r_sel;
    t_status          r_status;
    logic             r_found;
    logic [EW-1:0]    r_lo, r_hi, r_k, r_d;
    logic [SW1-1:0]   r_i;
    logic [SW-1:0]    r_s;
    logic [CNT_W-1:0] r_cnt;
    logic [SW-1:0]    r_nodes;
    logic [EW-1:0]    r_rtot, r_ctot;
    logic [EW-1:0]    r_rs_q, r_cs_q;
    logic             r_rs_qv, r_cs_qv;
    logic [IDX_W-1:0] r_re_q, r_ce_q;

    logic             r_ovalid;
    logic [STAT_W-1:0] r_ostatus;
    logic             r_ofound, r_onv, r_olast;
    logic [IDX_W-1:0] r_onb;
    logic [DEG_W-1:0] r_odeg;

    logic [SW-1:0]    w_idx;
    logic [IDX_W-1:0] w_val;
    logic [EW-1:0]    w_tot, w_qs, s_wdata;
    logic [IDX_W-1:0] w_qe, e_wdata;
    logic [SW-1:0]    s_raddr, s_waddr;
    logic [AW-1:0]    e_raddr, e_waddr;
    logic             s_rd_en, e_rd_en, e_wr_en;
    logic [XW-1:0]    w_row_x, w_col_x, w_nodes_x, w_nmax;
    logic             w_out_free;

    assign w_idx     = r_sel ? SW'(r_col) : SW'(r_row);
    assign w_val     = r_sel ? r_row : r_col;
    assign w_tot     = r_sel ? r_ctot : r_rtot;
    assign w_qs      = r_sel ? (r_cs_qv ? r_cs_q : '0) : (r_rs_qv ? r_rs_q : '0);
    assign w_qe      = r_sel ? r_ce_q : r_re_q;
    assign s_wdata   = i_cmd.adj_up ? (w_qs + r_d) : (w_qs - r_d);
    assign s_waddr   = SW'(r_i);
    assign s_rd_en   = (i_cmd.s_rd != SR_NONE);
    assign e_rd_en   = (i_cmd.e_rd != ER_NONE);
    assign e_wr_en   = (i_cmd.e_wr != WR_NONE);
    assign w_row_x   = XW'(r_row);
    assign w_col_x   = XW'(r_col);
    assign w_nodes_x = XW'(r_nodes);
    assign w_out_free = !r_ovalid || i_out_ready;

    always_comb begin
        case (i_cmd.s_rd)
            SR_IDX:  s_raddr = w_idx;
            SR_IDX1: s_raddr = w_idx + SW'(1);
            SR_SEG:  s_raddr = r_s;
            SR_SEG1: s_raddr = r_s + SW'(1);
            SR_I:    s_raddr = SW'(r_i);
            default: s_raddr = '0;
        endcase
        case (i_cmd.e_rd)
            ER_KM1:  e_raddr = AW'(r_k - EW'(1));
            ER_K:    e_raddr = AW'(r_k);
            ER_P:    e_raddr = AW'(r_lo);
            default: e_raddr = '0;
        endcase
        case (i_cmd.e_wr)
            WR_UP:   e_waddr = AW'(r_k);
            WR_POS:  e_waddr = AW'(r_hi);
            WR_DN:   e_waddr = AW'(r_k - r_d);
            default: e_waddr = '0;
        endcase
        e_wdata = (i_cmd.e_wr == WR_POS) ? w_val : w_qe;
        w_nmax = w_nodes_x;
        if (w_row_x + XW'(1) > w_nmax) w_nmax = w_row_x + XW'(1);
        if (w_col_x + XW'(1) > w_nmax) w_nmax = w_col_x + XW'(1);
    end

    // offset memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.s_wr && !r_sel) rs_mem[s_waddr] <= s_wdata;
        if (i_cmd.s_wr && r_sel)  cs_mem[s_waddr] <= s_wdata;
        if (s_rd_en) begin
            r_rs_q  <= rs_mem[s_raddr];
            r_cs_q  <= cs_mem[s_raddr];
            r_rs_qv <= r_rs_vld[s_raddr];
            r_cs_qv <= r_cs_vld[s_raddr];
        end
    end

    // valid bits stand in for the all-zero reset of the offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            for (int n = 0; n < NDEPTH; n++) begin
                r_rs_vld[n] <= 1'b0;
                r_cs_vld[n] <= 1'b0;
            end
        end else if (i_cmd.s_wr) begin
            if (r_sel) r_cs_vld[s_waddr] <= 1'b1;
            else       r_rs_vld[s_waddr] <= 1'b1;
        end
    end

    // entry memories
    always_ff @(posedge i_clk) begin
        if (e_wr_en && !r_sel) re_mem[e_waddr] <= e_wdata;
        if (e_wr_en && r_sel)  ce_mem[e_waddr] <= e_wdata;
        if (e_rd_en) begin
            r_re_q <= re_mem[e_raddr];
            r_ce_q <= ce_mem[e_raddr];
        end
    end

    // pointers and request fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req    <= i_req_type;
            r_row    <= i_row_index;
            r_col    <= i_col_index;
            r_status <= ST_OK;
            r_found  <= 1'b0;
        end
        if (i_cmd.st_set)    r_status <= i_cmd.st_val;
        if (i_cmd.found_set) r_found <= 1'b1;
        if (i_cmd.sel_set)       r_sel <= i_cmd.sel_val;
        else if (i_cmd.sel_flip) r_sel <= !r_sel;
        case (i_cmd.lo_op)
            LO_Q:    r_lo <= w_qs;
            LO_INC:  r_lo <= r_lo + EW'(1);
            default: ;
        endcase
        if (i_cmd.hi_ld) r_hi <= w_qs;
        case (i_cmd.k_op)
            K_TOT:   r_k <= w_tot;
            K_HI:    r_k <= r_hi;
            K_INC:   r_k <= r_k + EW'(1);
            K_DEC:   r_k <= r_k - EW'(1);
            K_LO1:   r_k <= r_lo + EW'(1);
            default: ;
        endcase
        case (i_cmd.d_op)
            D_SPAN:  r_d <= r_hi - r_lo;
            D_ONE:   r_d <= EW'(1);
            default: ;
        endcase
        case (i_cmd.i_op)
            I_IDX1:  r_i <= SW1'(w_idx) + SW1'(1);
            I_SEG1:  r_i <= SW1'(r_s) + SW1'(1);
            I_INC:   r_i <= r_i + SW1'(1);
            default: ;
        endcase
        case (i_cmd.s_op)
            S_ZERO:  r_s <= '0;
            S_INC:   r_s <= r_s + SW'(1);
            default: ;
        endcase
        case (i_cmd.c_op)
            C_CLR:   r_cnt <= '0;
            C_INC:   r_cnt <= r_cnt + CNT_W'(1);
            default: ;
        endcase
    end

    // store size state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_nodes <= '0;
            r_rtot  <= '0;
            r_ctot  <= '0;
        end else begin
            if (i_cmd.nodes_upd) r_nodes <= SW'(w_nmax);
            if (i_cmd.tot_upd) begin
                if (r_sel) r_ctot <= i_cmd.adj_up ? r_ctot + r_d : r_ctot - r_d;
                else       r_rtot <= i_cmd.adj_up ? r_rtot + r_d : r_rtot - r_d;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_stream) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_ostatus <= r_status;
            r_ofound  <= r_found;
            r_onv     <= 1'b0;
            r_onb     <= '0;
            r_odeg    <= '0;
            r_olast   <= 1'b1;
        end else if (i_cmd.emit_stream) begin
            r_ostatus <= ST_OK;
            r_ofound  <= 1'b0;
            r_onv     <= 1'b1;
            r_onb     <= w_qe;
            r_odeg    <= DEG_W'(r_d);
            r_olast   <= o_sts.last;
        end
    end

    always_comb begin
        o_sts.req        = r_req;
        o_sts.sel        = r_sel;
        o_sts.ins_oor    = (w_row_x >= XW'(MAX_NODES)) || (w_col_x >= XW'(MAX_NODES));
        o_sts.full       = (r_rtot >= EW'(MAX_EDGES)) || (r_ctot >= EW'(MAX_EDGES));
        o_sts.row_oor    = (w_row_x >= w_nodes_x);
        o_sts.col_oor    = (w_col_x >= w_nodes_x);
        o_sts.k_gt_hi    = (r_k > r_hi);
        o_sts.k_lt_tot   = (r_k < w_tot);
        o_sts.i_le_max   = (r_i <= SW1'(MAX_NODES));
        o_sts.s_lt_nodes = (r_s < r_nodes);
        o_sts.lo_lt_hi   = (r_lo < r_hi);
        o_sts.match      = (w_qe == w_val);
        o_sts.d_zero     = (r_d == '0);
        o_sts.last       = (LW'(r_cnt) + LW'(1) == LW'(r_d))
                           || (r_cnt == CNT_W'(RES_CAP - 1));
        o_sts.out_free   = w_out_free;
    end

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_ostatus;
    assign o_found           = r_ofound;
    assign o_neighbour_valid = r_onv;
    assign o_neighbour       = r_onb;
    assign o_degree          = r_odeg;
    assign o_last            = r_olast;

endmodule

@@ hdl/sas_ctrl.sv @@
// Controller: sequences each request as reads, shifts, offset sweeps and scans.
module sas_ctrl import sas_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SM_IDLE;
            r_ret   <= RET_INS;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        o_cmd        = '0;
        o_cmd.adj_up = (r_ret == RET_INS);
        o_in_ready   = 1'b0;
        case (r_state)
            SM_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = SM_DECODE;
                end
            end
            SM_DECODE: begin
                n_state = SM_EMIT;
                case (i_sts.req)
                    REQ_INSERT: begin
                        if (i_sts.ins_oor) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_RANGE;
                        end else if (i_sts.full) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_FULL;
                        end else begin
                            o_cmd.nodes_upd = 1'b1;
                            o_cmd.sel_set   = 1'b1;
                            o_cmd.sel_val   = 1'b0;
                            n_ret   = RET_INS;
                            n_state = SM_INS_RDPOS;
                        end
                    end
                    REQ_CONTAINS: begin
                        if (i_sts.row_oor || i_sts.col_oor) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_RANGE;
                        end else begin
                            o_cmd.sel_set = 1'b1;
                            o_cmd.sel_val = 1'b0;
                            n_state = SM_SEG_A;
                        end
                    end
                    REQ_READ_ROW, REQ_CLEAR_ROW: begin
                        if (i_sts.row_oor) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_RANGE;
                        end else begin
                            o_cmd.sel_set = 1'b1;
                            o_cmd.sel_val = 1'b0;
                            n_ret   = RET_CLR;
                            n_state = SM_SEG_A;
                        end
                    end
                    REQ_READ_COL, REQ_CLEAR_COL: begin
                        if (i_sts.col_oor) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_RANGE;
                        end else begin
                            o_cmd.sel_set = 1'b1;
                            o_cmd.sel_val = 1'b1;
                            n_ret   = RET_CLR;
                            n_state = SM_SEG_A;
                        end
                    end
                    REQ_CLEAR_ALL: o_cmd.clr_all = 1'b1;
                    default: ;
                endcase
            end
            SM_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state = SM_IDLE;
                end
            end
            // insert: open a slot at the end of the segment, then bump offsets
            SM_INS_RDPOS: begin
                o_cmd.s_rd = SR_IDX1;
                n_state = SM_INS_POS;
            end
            SM_INS_POS: begin
                o_cmd.hi_ld = 1'b1;
                o_cmd.k_op  = K_TOT;
                n_state = SM_INS_SHCHK;
            end
            SM_INS_SHCHK: begin
                if (i_sts.k_gt_hi) begin
                    o_cmd.e_rd = ER_KM1;
                    n_state = SM_INS_SHWR;
                end else begin
                    o_cmd.e_wr = WR_POS;
                    o_cmd.i_op = I_IDX1;
                    o_cmd.d_op = D_ONE;
                    n_state = SM_ADJ_RD;
                end
            end
            SM_INS_SHWR: begin
                o_cmd.e_wr = WR_UP;
                o_cmd.k_op = K_DEC;
                n_state = SM_INS_SHCHK;
            end
            // offset sweep from i up to the end marker
            SM_ADJ_RD: begin
                if (i_sts.i_le_max) begin
                    o_cmd.s_rd = SR_I;
                    n_state = SM_ADJ_WR;
                end else begin
                    o_cmd.tot_upd = 1'b1;
                    case (r_ret)
                        RET_INS: begin
                            if (!i_sts.sel) begin
                                o_cmd.sel_flip = 1'b1;
                                n_state = SM_INS_RDPOS;
                            end else begin
                                n_state = SM_EMIT;
                            end
                        end
                        RET_CLR: begin
                            o_cmd.sel_flip = 1'b1;
                            o_cmd.s_op     = S_ZERO;
                            n_ret   = RET_SWEEP;
                            n_state = SM_SW_SEG;
                        end
                        default: begin
                            o_cmd.s_op = S_INC;
                            n_state = SM_SW_SEG;
                        end
                    endcase
                end
            end
            SM_ADJ_WR: begin
                o_cmd.s_wr = 1'b1;
                o_cmd.i_op = I_INC;
                n_state = SM_ADJ_RD;
            end
            // segment bounds of the requested row or column
            SM_SEG_A: begin
                o_cmd.s_rd = SR_IDX;
                n_state = SM_SEG_B;
            end
            SM_SEG_B: begin
                o_cmd.lo_op = LO_Q;
                o_cmd.s_rd  = SR_IDX1;
                n_state = SM_SEG_C;
            end
            SM_SEG_C: begin
                o_cmd.hi_ld = 1'b1;
                n_state = SM_SEG_D;
            end
            SM_SEG_D: begin
                o_cmd.d_op = D_SPAN;
                o_cmd.k_op = K_HI;
                o_cmd.c_op = C_CLR;
                case (i_sts.req)
                    REQ_CONTAINS:                n_state = SM_SC_CHK;
                    REQ_READ_ROW, REQ_READ_COL:  n_state = SM_RD_CHK;
                    default:                     n_state = SM_DN_CHK;
                endcase
            end
            // close a gap of d entries just below k by moving the entries from k down
            SM_DN_CHK: begin
                if (i_sts.k_lt_tot) begin
                    o_cmd.e_rd = ER_K;
                    n_state = SM_DN_WR;
                end else begin
                    o_cmd.i_op = (r_ret == RET_CLR) ? I_IDX1 : I_SEG1;
                    n_state = SM_ADJ_RD;
                end
            end
            SM_DN_WR: begin
                o_cmd.e_wr = WR_DN;
                o_cmd.k_op = K_INC;
                n_state = SM_DN_CHK;
            end
            // other copy: drop the first match in each segment
            SM_SW_SEG: begin
                if (i_sts.s_lt_nodes) begin
                    o_cmd.s_rd = SR_SEG;
                    n_state = SM_SW_RDHI;
                end else begin
                    n_state = SM_EMIT;
                end
            end
            SM_SW_RDHI: begin
                o_cmd.lo_op = LO_Q;
                o_cmd.s_rd  = SR_SEG1;
                n_state = SM_SW_HI;
            end
            SM_SW_HI: begin
                o_cmd.hi_ld = 1'b1;
                n_state = SM_SC_CHK;
            end
            SM_SC_CHK: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.e_rd = ER_P;
                    n_state = SM_SC_CMP;
                end else if (i_sts.req == REQ_CONTAINS) begin
                    n_state = SM_EMIT;
                end else begin
                    o_cmd.s_op = S_INC;
                    n_state = SM_SW_SEG;
                end
            end
            SM_SC_CMP: begin
                if (i_sts.match) begin
                    if (i_sts.req == REQ_CONTAINS) begin
                        o_cmd.found_set = 1'b1;
                        n_state = SM_EMIT;
                    end else begin
                        o_cmd.d_op = D_ONE;
                        o_cmd.k_op = K_LO1;
                        n_state = SM_DN_CHK;
                    end
                end else begin
                    o_cmd.lo_op = LO_INC;
                    n_state = SM_SC_CHK;
                end
            end
            // streaming read
            SM_RD_CHK: n_state = i_sts.d_zero ? SM_EMIT : SM_ST_RD;
            SM_ST_RD: begin
                o_cmd.e_rd = ER_P;
                n_state = SM_ST_EM;
            end
            SM_ST_EM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_stream = 1'b1;
                    o_cmd.lo_op = LO_INC;
                    o_cmd.c_op  = C_INC;
                    n_state = i_sts.last ? SM_IDLE : SM_ST_RD;
                end
            end
            default: n_state = SM_IDLE;
        endcase
    end

endmodule

@@ hdl/sparse_adjacency_store.sv @@
// Top level of the sparse adjacency store: controller, datapath and checks.
// Sequencing: insert shifts the later entries up and rewrites every following offset,
//   for each copy; clears add a scan of every segment of the other copy; contains
//   scans one segment; reads stream the entries one by one after the segment bounds.
// One transaction at a time; the single-port walks over the entry and offset
//   memories set the cost of an insert or a clear.
// Reset: synchronous, active low; offsets read as zero through per-entry valid bits,
//   no clearing pass; entry memories are undefined until written.
module sparse_adjacency_store import sas_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [IDX_W-1:0]  i_row_index,
    input  logic [IDX_W-1:0]  i_col_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic              o_found,
    output logic              o_neighbour_valid,
    output logic [IDX_W-1:0]  o_neighbour,
    output logic [DEG_W-1:0]  o_degree,
    output logic              o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller owns sequencing; it sees only the input valid and the datapath status
    sas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath holds both copies and the result register
    sas_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_req_type        (i_req_type),
        .i_row_index       (i_row_index),
        .i_col_index       (i_col_index),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_found           (o_found),
        .o_neighbour_valid (o_neighbour_valid),
        .o_neighbour       (o_neighbour),
        .o_degree          (o_degree),
        .o_last            (o_last)
    );

    // a new result is only loaded when the result register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_single || cmd.emit_stream) |-> sts.out_free)
        else $error("result register overwritten");

    // block stays busy while a non-final result of a transaction is pending
    a_busy_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("new transaction taken mid stream");

    // offset writes never run past the end marker
    a_adj_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.s_wr |-> sts.i_le_max)
        else $error("offset sweep out of range");

endmodule
